### src/cri_pkg.sv
// Shared types and constants for the colour ramp interpolator.
// No dependencies.
package cri_pkg;

    localparam int unsigned MaxPointsDef = 16;
    localparam int unsigned HeightW      = 16;
    localparam int unsigned ChanW        = 8;
    localparam int unsigned ColourW      = 4 * ChanW;
    localparam int unsigned MaxShift     = 8;
    localparam int unsigned FracW        = MaxShift + 1;
    // numerator h - h1 and divisor h2 - h1 are both below 2^17
    localparam int unsigned DiffW        = HeightW + 1;
    // quotient numerator: diff << L, L up to MaxShift
    localparam int unsigned NumW         = DiffW + MaxShift;

    localparam logic [1:0] CfgNumPoints  = 2'd0;
    localparam logic [1:0] CfgBlendShift = 2'd1;
    localparam logic [1:0] CfgUseAlpha   = 2'd2;

    localparam logic FuncWrite = 1'b0;
    localparam logic FuncQuery = 1'b1;

    typedef logic [ColourW-1:0] t_colour;

    // the search result handed from the lookup to the divider
    typedef struct packed {
        logic               blend;   // 1: interpolate c1/c2, 0: pass c1
        logic [3:0]         lvl;
        logic               alpha;
        logic [DiffW-1:0]   num;
        logic [DiffW-1:0]   den;
        t_colour            c1;
        t_colour            c2;
    } t_seg;

endpackage

### src/color_ramp_interpolator_unit.sv
// Colour ramp interpolator: maps a signed 16-bit height to RGBA through a
// table of up to MAX_POINTS control points, loaded by write items (tuser=0).
// One item is accepted per cycle while the output is not stalled; a query's
// colour is presented after twelve register stages: the two search
// stages, the nine-stage fraction divider and the blend stage. The whole
// pipeline advances together and halts while the output holds an item that
// is not taken. Depends on cri_pkg, cri_lookup and cri_blend.
module color_ramp_interpolator_unit #(
    parameter int unsigned MAX_POINTS = cri_pkg::MaxPointsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // point_index[3:0], point_height[19:4], red[27:20], green[35:28],
    // blue[43:36], alpha[51:44], query_height[67:52], zero pad
    input  logic [71:0] s_axis_tdata,
    input  logic        s_axis_tuser,   // func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_red[7:0], out_green[15:8], out_blue[23:16], out_alpha[31:24]
    output logic [31:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [4:0]  i_cfg_data
);
    logic [4:0] r_num_points;
    logic [3:0] r_blend_shift;
    logic       r_use_alpha;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_points  <= 5'd2;
            r_blend_shift <= 4'd0;
            r_use_alpha   <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                cri_pkg::CfgNumPoints:  r_num_points  <= i_cfg_data;
                cri_pkg::CfgBlendShift: r_blend_shift <= i_cfg_data[3:0];
                cri_pkg::CfgUseAlpha:   r_use_alpha   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic w_en, w_acc, w_lv, w_bv;
    cri_pkg::t_seg w_seg;
    cri_pkg::t_colour w_col;

    assign w_en          = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;
    assign w_acc         = s_axis_tvalid && w_en;

    cri_lookup #(.MAX_POINTS(MAX_POINTS)) u_lookup (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_wr(w_acc && (s_axis_tuser == cri_pkg::FuncWrite)),
        .i_qv(w_acc && (s_axis_tuser == cri_pkg::FuncQuery)),
        .i_idx(s_axis_tdata[3:0]),
        .i_ph(s_axis_tdata[19:4]),
        .i_pc(s_axis_tdata[51:20]),
        .i_qh(s_axis_tdata[67:52]),
        .i_num_points(r_num_points), .i_blend_shift(r_blend_shift),
        .i_use_alpha(r_use_alpha),
        .o_valid(w_lv), .o_seg(w_seg)
    );

    cri_blend u_blend (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_valid(w_lv), .i_seg(w_seg),
        .o_valid(w_bv), .o_colour(w_col)
    );

    assign m_axis_tvalid = w_bv;
    assign m_axis_tdata  = w_col;

endmodule

### src/cri_lookup.sv
// Control point table and segment search (two register stages).
// Depends on cri_pkg.
module cri_lookup #(
    parameter int unsigned MAX_POINTS = cri_pkg::MaxPointsDef
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_wr,
    input  logic                              i_qv,
    input  logic [3:0]                        i_idx,
    input  logic signed [cri_pkg::HeightW-1:0] i_ph,
    input  cri_pkg::t_colour                  i_pc,
    input  logic signed [cri_pkg::HeightW-1:0] i_qh,
    input  logic [4:0]                        i_num_points,
    input  logic [3:0]                        i_blend_shift,
    input  logic                              i_use_alpha,
    output logic                              o_valid,
    output cri_pkg::t_seg                     o_seg
);
    localparam int unsigned IdxW = $clog2(MAX_POINTS);
    localparam int unsigned CntW = $clog2(MAX_POINTS + 1);

    logic signed [cri_pkg::HeightW-1:0] r_h [MAX_POINTS];
    cri_pkg::t_colour                   r_c [MAX_POINTS];

    // stage 1: compare against every point
    logic                               r_v1;
    logic [MAX_POINTS-1:0]              r_ge;
    logic signed [cri_pkg::HeightW-1:0] r_qh1;
    logic [CntW-1:0]                    r_n1;
    logic [3:0]                         r_l1;
    logic                               r_a1;

    logic [CntW-1:0] n_cnt;
    logic [3:0]      n_lvl;
    logic [MAX_POINTS-1:0] n_ge;

    always_comb begin
        if (i_num_points < 5'd2) n_cnt = CntW'(2);
        else if (32'(i_num_points) > MAX_POINTS) n_cnt = CntW'(MAX_POINTS);
        else n_cnt = CntW'(i_num_points);
        n_lvl = (i_blend_shift > 4'(cri_pkg::MaxShift)) ? 4'(cri_pkg::MaxShift)
                                                         : i_blend_shift;
        for (int i = 0; i < MAX_POINTS; i++) begin
            n_ge[i] = (i_qh >= r_h[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_wr && (32'(i_idx) < MAX_POINTS)) begin
            r_h[IdxW'(i_idx)] <= i_ph;
            r_c[IdxW'(i_idx)] <= i_pc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_qv;
            o_valid <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ge  <= n_ge;
            r_qh1 <= i_qh;
            r_n1  <= n_cnt;
            r_l1  <= n_lvl;
            r_a1  <= i_use_alpha;
        end
    end

    // stage 2: pick the highest point at or below h, mux the pair
    logic [IdxW-1:0] n_lo;
    logic            n_top;
    logic            n_found;
    logic [IdxW-1:0] n_last;
    cri_pkg::t_seg   n_seg;

    always_comb begin
        n_last  = IdxW'(r_n1 - CntW'(1));
        n_top   = r_ge[n_last];
        n_found = 1'b0;
        n_lo    = '0;
        for (int i = 1; i < MAX_POINTS; i++) begin
            if (CntW'(i) < r_n1 && r_ge[i-1]) begin
                n_found = 1'b1;
                n_lo    = IdxW'(i - 1);
            end
        end
        n_seg       = '0;
        n_seg.lvl   = r_l1;
        n_seg.alpha = r_a1;
        if (n_top) begin
            n_seg.c1 = r_c[n_last];
        end else if (!n_found) begin
            n_seg.c1 = r_c[0];
        end else begin
            n_seg.c1    = r_c[n_lo];
            n_seg.c2    = r_c[n_lo + IdxW'(1)];
            n_seg.blend = (r_l1 != 4'd0);
            n_seg.num   = cri_pkg::DiffW'({r_qh1[cri_pkg::HeightW-1], r_qh1})
                        - cri_pkg::DiffW'({r_h[n_lo][cri_pkg::HeightW-1], r_h[n_lo]});
            n_seg.den   = cri_pkg::DiffW'({r_h[n_lo + IdxW'(1)][cri_pkg::HeightW-1],
                                           r_h[n_lo + IdxW'(1)]})
                        - cri_pkg::DiffW'({r_h[n_lo][cri_pkg::HeightW-1], r_h[n_lo]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) o_seg <= n_seg;
    end

endmodule

### src/cri_blend.sv
// Pipelined restoring divider for the fraction, then channel blend.
// Depends on cri_pkg.
module cri_blend (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  cri_pkg::t_seg          i_seg,
    output logic                   o_valid,
    output cri_pkg::t_colour       o_colour
);
    localparam int unsigned NumW  = cri_pkg::NumW;
    localparam int unsigned DiffW = cri_pkg::DiffW;
    localparam int unsigned FracW = cri_pkg::FracW;
    localparam int unsigned ChanW = cri_pkg::ChanW;

    // one quotient bit per stage; only the low FracW bits matter since f <= 2^L
    // and num < den, so quotient < 2^L fits FracW bits; remainder < den.
    localparam int unsigned Steps = FracW;

    logic [Steps:0]          r_v;
    cri_pkg::t_seg           r_s  [Steps+1];
    logic [DiffW-1:0]        r_rem[Steps+1];
    logic [FracW-1:0]        r_q  [Steps+1];

    always_comb begin
        r_v[0]   = i_valid;
        r_s[0]   = i_seg;
        r_rem[0] = '0;
        r_q[0]   = '0;
    end

    // numerator is num << lvl; feed its bits MSB first. Bits of num above
    // the fraction range give zero quotient (num < den), so start with
    // rem = num >> (FracW - lvl) and shift in the rest.
    for (genvar s = 0; s < Steps; s++) begin : g_div
        logic [NumW-1:0]   w_n;
        logic [DiffW:0]    w_t;
        logic [DiffW-1:0]  w_r;
        always_comb begin
            w_n = NumW'(r_s[s].num) << r_s[s].lvl;
            if (s == 0) w_r = DiffW'(w_n >> FracW);
            else        w_r = r_rem[s];
            w_t = {w_r, w_n[FracW-1-s]};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_v[s+1] <= 1'b0;
            else if (i_en) r_v[s+1] <= r_v[s];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_s[s+1] <= r_s[s];
                if (w_t >= {1'b0, r_s[s].den}) begin
                    r_rem[s+1] <= DiffW'(w_t - {1'b0, r_s[s].den});
                    r_q[s+1]   <= {r_q[s][FracW-2:0], 1'b1};
                end else begin
                    r_rem[s+1] <= DiffW'(w_t);
                    r_q[s+1]   <= {r_q[s][FracW-2:0], 1'b0};
                end
            end
        end
    end

    // blend stage: 9x8 multiplies per channel, then shift
    logic [FracW-1:0]   w_scale, w_f, w_of;
    cri_pkg::t_colour   n_col;
    logic [FracW+ChanW:0] w_sum;
    cri_pkg::t_seg      w_s;

    always_comb begin
        w_s     = r_s[Steps];
        w_scale = FracW'(1) << w_s.lvl;
        w_f     = (r_q[Steps] > w_scale) ? w_scale : r_q[Steps];
        w_of    = w_scale - w_f;
        n_col   = w_s.c1;
        w_sum   = '0;
        if (w_s.blend) begin
            for (int k = 0; k < 4; k++) begin
                w_sum = (FracW+ChanW+1)'(w_f * w_s.c2[k*ChanW +: ChanW])
                      + (FracW+ChanW+1)'(w_of * w_s.c1[k*ChanW +: ChanW]);
                n_col[k*ChanW +: ChanW] = ChanW'(w_sum >> w_s.lvl);
            end
        end
        if (!w_s.alpha) n_col[3*ChanW +: ChanW] = '1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else if (i_en) o_valid <= r_v[Steps];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) o_colour <= n_col;
    end

endmodule
